/* rtl/nsfe_pkg.sv */
// nsfe_pkg: shared types, constants and helper functions for the NMEA field extractor
// no dependencies; imported by nsfe_core, nsfe_obuf, the top module and the testbench checker
package nsfe_pkg;

  localparam int unsigned MaxSentenceLen = 128;
  localparam int unsigned LenW = 10;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_HEADER  = 3'd1;
  localparam logic [2:0] PH_BODY    = 3'd2;
  localparam logic [2:0] PH_CK_HIGH = 3'd3;
  localparam logic [2:0] PH_CK_LOW  = 3'd4;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;

  localparam logic CfgFieldCharLimit = 1'b0;
  localparam logic CfgTypeEnableMask = 1'b1;

  localparam logic KindChar = 1'b0;
  localparam logic KindEnd  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [1:0] sentence_type;
    logic [4:0] field_index;
    logic [5:0] char_position;
    logic [7:0] char_value;
    logic       checksum_ok;
  } res_t;

  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c > 8'h40) v = c - 8'h37;
    else v = c - 8'h30;
    return v;
  endfunction

  // sentence type candidates per header byte: bit 0 RMC, 1 GGA, 2 GSA, 3 GSV
  function automatic logic [3:0] header_filter(input logic [2:0] idx, input logic [7:0] c);
    logic [3:0] m;
    m = 4'd0;
    case (idx)
      3'd2: begin
        if (c == 8'h52) m = 4'b0001;
        if (c == 8'h47) m = 4'b1110;
      end
      3'd3: begin
        if (c == 8'h4D) m = 4'b0001;
        if (c == 8'h47) m = 4'b0010;
        if (c == 8'h53) m = 4'b1100;
      end
      3'd4: begin
        if (c == 8'h43) m = 4'b0001;
        if (c == 8'h41) m = 4'b0110;
        if (c == 8'h56) m = 4'b1000;
      end
      default: m = 4'b1111;
    endcase
    return m;
  endfunction

endpackage

/* rtl/nsfe_core.sv */
// nsfe_core: per-byte sentence state, checksum and field result generation
// depends on nsfe_pkg
module nsfe_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [5:0]       cfg_data_i,
  input  logic             byte_we_i,
  input  logic [7:0]       byte_i,
  output logic             res_valid_o,
  output nsfe_pkg::res_t   res_o
);
  import nsfe_pkg::*;

  logic [5:0]      limit_q;
  logic [3:0]      mask_q;
  logic [2:0]      phase_q, phase_d;
  logic [2:0]      hcnt_q, hcnt_d;
  logic [3:0]      hmatch_q, hmatch_d;
  logic [7:0]      xor_q, xor_d;
  logic [3:0]      hi_q, hi_d;
  logic [4:0]      field_q, field_d;
  logic [5:0]      pos_q, pos_d;
  logic [LenW-1:0] len_q, len_d;
  logic [1:0]      type_q, type_d;

  logic [3:0] m;
  logic [7:0] hexv;
  logic [7:0] got;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 6'd16;
      mask_q  <= 4'd15;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFieldCharLimit: limit_q <= cfg_data_i;
        CfgTypeEnableMask: mask_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d  = phase_q;
    hcnt_d   = hcnt_q;
    hmatch_d = hmatch_q;
    xor_d    = xor_q;
    hi_d     = hi_q;
    field_d  = field_q;
    pos_d    = pos_q;
    len_d    = len_q;
    type_d   = type_q;
    m        = hmatch_q & header_filter(hcnt_q, byte_i) & mask_q;
    hexv     = hex_value(byte_i);
    got      = {hi_q, 4'd0} + hexv;
    res_valid_o         = 1'b0;
    res_o.kind          = KindEnd;
    res_o.sentence_type = type_q;
    res_o.field_index   = field_q;
    res_o.char_position = 6'd0;
    res_o.char_value    = 8'd0;
    res_o.checksum_ok   = 1'b0;
    if (byte_i == ChDollar) begin
      if (phase_q == PH_BODY || phase_q == PH_CK_HIGH || phase_q == PH_CK_LOW) begin
        res_valid_o = 1'b1;
      end
      phase_d  = PH_HEADER;
      hcnt_d   = 3'd0;
      hmatch_d = 4'd15;
      xor_d    = 8'd0;
      hi_d     = 4'd0;
      field_d  = 5'd0;
      pos_d    = 6'd0;
      len_d    = '0;
    end else begin
      case (phase_q)
        PH_HEADER: begin
          xor_d    = xor_q ^ byte_i;
          len_d    = len_q + 1'b1;
          hmatch_d = hmatch_q & header_filter(hcnt_q, byte_i);
          hcnt_d   = hcnt_q + 3'd1;
          if (hcnt_d >= 3'd5) begin
            phase_d = PH_BODY;
            if (m[0]) type_d = 2'd0;
            else if (m[1]) type_d = 2'd1;
            else if (m[2]) type_d = 2'd2;
            else if (m[3]) type_d = 2'd3;
            else phase_d = PH_IDLE;
          end
        end
        PH_BODY: begin
          if (byte_i == ChStar) begin
            phase_d = PH_CK_HIGH;
          end else if (len_q >= LenW'(MaxSentenceLen)) begin
            res_valid_o = 1'b1;
            phase_d     = PH_IDLE;
          end else begin
            xor_d = xor_q ^ byte_i;
            len_d = len_q + 1'b1;
            if (byte_i == ChComma) begin
              if (field_q != 5'd31) field_d = field_q + 5'd1;
              pos_d = 6'd0;
            end else begin
              if (pos_q < limit_q) begin
                res_valid_o         = 1'b1;
                res_o.kind          = KindChar;
                res_o.char_position = pos_q;
                res_o.char_value    = byte_i;
              end
              if (pos_q != 6'd63) pos_d = pos_q + 6'd1;
            end
          end
        end
        PH_CK_HIGH: begin
          hi_d    = hexv[3:0];
          phase_d = PH_CK_LOW;
        end
        PH_CK_LOW: begin
          res_valid_o       = 1'b1;
          res_o.checksum_ok = (got == xor_q);
          phase_d           = PH_IDLE;
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      hcnt_q   <= 3'd0;
      hmatch_q <= 4'd0;
      xor_q    <= 8'd0;
      hi_q     <= 4'd0;
      field_q  <= 5'd0;
      pos_q    <= 6'd0;
      len_q    <= '0;
      type_q   <= 2'd0;
    end else if (byte_we_i) begin
      phase_q  <= phase_d;
      hcnt_q   <= hcnt_d;
      hmatch_q <= hmatch_d;
      xor_q    <= xor_d;
      hi_q     <= hi_d;
      field_q  <= field_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      type_q   <= type_d;
    end
  end

endmodule

/* rtl/nsfe_obuf.sv */
// nsfe_obuf: two-entry result buffer that decouples input ready from output ready
// depends on nsfe_pkg
module nsfe_obuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nsfe_pkg::res_t data_i,
  output logic           room_o,
  output logic           valid_o,
  input  logic           ready_i,
  output nsfe_pkg::res_t data_o
);
  import nsfe_pkg::*;

  res_t       head_q, head_d;
  res_t       tail_q, tail_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign room_o  = (cnt_q != 2'd2);
  assign data_o  = head_q;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    case ({push_i, pop})
      2'b10: begin
        if (cnt_q == 2'd0) head_d = data_i;
        else tail_d = data_i;
        cnt_d = cnt_q + 2'd1;
      end
      2'b01: begin
        head_d = tail_q;
        cnt_d  = cnt_q - 2'd1;
      end
      2'b11: begin
        if (cnt_q == 2'd1) begin
          head_d = data_i;
        end else begin
          head_d = tail_q;
          tail_d = data_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= 2'd0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

/* rtl/nmea_sentence_field_extractor_top.sv */
// nmea_sentence_field_extractor_top: NMEA byte stream in, field characters and sentence ends out
// depends on nsfe_pkg, nsfe_core, nsfe_obuf
//
// One byte is taken every cycle while s_axis_tready is high; its result, if any, is registered in the
// two-entry output buffer that holds results, so the input only stalls when
// two results wait downstream. Sentence types RMC, GGA, GSA and GSV are recognized from the
// header; m_axis_tuser is 0 for a field character and 1 for a sentence end whose checksum_ok bit
// gives the verdict. Sentences longer than 128 bytes without '*' end with a failing verdict.
// Registers: index 0 field_char_limit (6 bits, reset 16), index 1 type_enable_mask (reset 15).
module nmea_sentence_field_extractor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_in[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // sentence_type, field_index, char_position,
                                      // char_value, checksum_ok, zero pad
  output logic        m_axis_tuser    // kind
);
  import nsfe_pkg::*;

  logic byte_we;
  logic res_valid;
  res_t res, head;

  assign cfg_ready_o = 1'b1;
  assign byte_we     = s_axis_tvalid && s_axis_tready;

  nsfe_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .byte_we_i   (byte_we),
    .byte_i      (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  nsfe_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (byte_we && res_valid),
    .data_i  (res),
    .room_o  (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (head)
  );

  assign m_axis_tuser = head.kind;
  assign m_axis_tdata = {2'b00, head.checksum_ok, head.char_value, head.char_position,
                         head.field_index, head.sentence_type};

endmodule

/* rtl/nsfe_checker.sv */
// nsfe_checker: port-level checks of the extractor output stream
// depends on nmea_sentence_field_extractor_top; bound to it below
module nsfe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transfer dropped while stalled");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending result");

  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[20:7] == 14'd0)
    else $error("sentence end carries character data");

  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> !m_axis_tdata[21] && m_axis_tdata[12:7] != 6'd63)
    else $error("malformed field character");

endmodule

bind nmea_sentence_field_extractor_top nsfe_checker u_nsfe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/sv/nmea_sentence_field_extractor_checker.sv */
// nmea_sentence_field_extractor_checker: watches the byte, register and result channels,
// predicts every field character and sentence end, and compares them with the block output
// depends on nsfe_pkg
module nmea_sentence_field_extractor_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,
  input  logic        m_tuser_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          chars_o,
  output int          ends_o,
  output int          ends_ok_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import nsfe_pkg::*;

  localparam logic [3:0][23:0] TypeTags = {"GSV", "GSA", "GGA", "RMC"};

  logic [5:0] field_limit;
  logic [3:0] type_mask;
  logic [2:0] parse_phase;
  logic [2:0] hdr_count;
  logic [3:0] hdr_cand;
  logic [7:0] xor_acc;
  logic [3:0] ck_high;
  logic [4:0] field_idx;
  logic [5:0] char_pos;
  logic [9:0] sent_len;
  logic [1:0] cur_type;
  res_t       expected_q[$];

  function automatic logic [7:0] hex_digit(input logic [7:0] c);
    return (c > 8'h40) ? c - 8'h37 : c - 8'h30;
  endfunction

  function automatic logic [3:0] type_candidates(input logic [2:0] idx, input logic [7:0] c);
    logic [3:0] m;
    int         t;
    if (idx < 3'd2 || idx > 3'd4) return 4'hF;
    m = 4'h0;
    for (t = 0; t < 4; t++)
      if (TypeTags[t][8*(4-idx) +: 8] == c) m[t] = 1'b1;
    return m;
  endfunction

  function automatic void expect_result(input logic kind, input logic [5:0] pos,
                                        input logic [7:0] ch, input logic ok);
    res_t r;
    r.kind          = kind;
    r.sentence_type = cur_type;
    r.field_index   = field_idx;
    r.char_position = pos;
    r.char_value    = ch;
    r.checksum_ok   = ok;
    expected_q.push_back(r);
  endfunction

  function automatic void step_parser(input logic [7:0] c);
    logic [3:0] hit;
    logic [7:0] digit;
    if (c == ChDollar) begin
      // a new sentence closes a kept one that already reached its body
      if (parse_phase == PH_BODY || parse_phase == PH_CK_HIGH || parse_phase == PH_CK_LOW)
        expect_result(KindEnd, 6'd0, 8'd0, 1'b0);
      parse_phase = PH_HEADER;
      hdr_count   = 3'd0;
      hdr_cand    = 4'hF;
      xor_acc     = 8'd0;
      ck_high     = 4'd0;
      field_idx   = 5'd0;
      char_pos    = 6'd0;
      sent_len    = 10'd0;
      return;
    end
    case (parse_phase)
      PH_HEADER: begin
        xor_acc   = xor_acc ^ c;
        sent_len  = sent_len + 10'd1;
        hdr_cand  = hdr_cand & type_candidates(hdr_count, c);
        hdr_count = hdr_count + 3'd1;
        if (hdr_count >= 3'd5) begin
          hit = hdr_cand & type_mask;
          parse_phase = PH_BODY;
          if (hit[0]) cur_type = 2'd0;
          else if (hit[1]) cur_type = 2'd1;
          else if (hit[2]) cur_type = 2'd2;
          else if (hit[3]) cur_type = 2'd3;
          else parse_phase = PH_IDLE;
        end
      end
      PH_BODY: begin
        if (c == ChStar) begin
          parse_phase = PH_CK_HIGH;
        end else if (sent_len >= MaxSentenceLen) begin
          expect_result(KindEnd, 6'd0, 8'd0, 1'b0);
          parse_phase = PH_IDLE;
        end else begin
          xor_acc  = xor_acc ^ c;
          sent_len = sent_len + 10'd1;
          if (c == ChComma) begin
            if (field_idx != 5'd31) field_idx = field_idx + 5'd1;
            char_pos = 6'd0;
          end else begin
            if (char_pos < field_limit) expect_result(KindChar, char_pos, c, 1'b0);
            if (char_pos != 6'd63) char_pos = char_pos + 6'd1;
          end
        end
      end
      PH_CK_HIGH: begin
        digit       = hex_digit(c);
        ck_high     = digit[3:0];
        parse_phase = PH_CK_LOW;
      end
      PH_CK_LOW: begin
        digit = {ck_high, 4'h0} + hex_digit(c);
        expect_result(KindEnd, 6'd0, 8'd0, digit == xor_acc);
        parse_phase = PH_IDLE;
      end
      default: parse_phase = PH_IDLE;
    endcase
  endfunction

  function automatic int field_mismatch(input string name, input int want, input int got);
    if (want == got) return 0;
    $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    return 1;
  endfunction

  function automatic void check_result();
    res_t want;
    res_t got;
    int   bad;
    got.kind          = m_tuser_i;
    got.sentence_type = m_tdata_i[1:0];
    got.field_index   = m_tdata_i[6:2];
    got.char_position = m_tdata_i[12:7];
    got.char_value    = m_tdata_i[20:13];
    got.checksum_ok   = m_tdata_i[21];
    if (got.kind == KindEnd) begin
      ends_o++;
      if (got.checksum_ok) ends_ok_o++;
    end else begin
      chars_o++;
    end
    if (expected_q.size() == 0) begin
      $display("%0t: result with none expected, kind %0d tdata %h", $time, m_tuser_i,
               m_tdata_i);
      fail_count_o++;
      return;
    end
    want = expected_q.pop_front();
    bad  = field_mismatch("kind", want.kind, got.kind);
    bad += field_mismatch("sentence_type", want.sentence_type, got.sentence_type);
    bad += field_mismatch("field_index", want.field_index, got.field_index);
    bad += field_mismatch("char_position", want.char_position, got.char_position);
    bad += field_mismatch("char_value", want.char_value, got.char_value);
    bad += field_mismatch("checksum_ok", want.checksum_ok, got.checksum_ok);
    if (bad != 0) fail_count_o++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_limit  = 6'd16;
      type_mask    = 4'hF;
      parse_phase  = PH_IDLE;
      hdr_count    = 3'd0;
      hdr_cand     = 4'd0;
      xor_acc      = 8'd0;
      ck_high      = 4'd0;
      field_idx    = 5'd0;
      char_pos     = 6'd0;
      sent_len     = 10'd0;
      cur_type     = 2'd0;
      expected_q.delete();
      fail_count_o = 0;
      chars_o      = 0;
      ends_o       = 0;
      ends_ok_o    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_result();
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgFieldCharLimit) field_limit = cfg_data_i;
        else type_mask = cfg_data_i[3:0];
      end
      if (s_tvalid_i && s_tready_i) step_parser(s_tdata_i);
    end
    pending_o = expected_q.size();
  end

endmodule

/* tb/sv/nmea_sentence_field_extractor_top_test.sv */
// nmea_sentence_field_extractor_top_test: drives NMEA sentences, noise and register writes into
// the field extractor and gives the verdict from the checker's failure and pending counts
// depends on nsfe_pkg, nmea_sentence_field_extractor_top, nmea_sentence_field_extractor_checker
module nmea_sentence_field_extractor_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nsfe_pkg::*;

  localparam int CycleLimit = 200000;

  typedef enum int {CK_GOOD, CK_BAD, CK_RAW, CK_NONE} ck_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [5:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  int fail_count;
  int pending;
  int chars_seen;
  int ends_seen;
  int ends_ok;
  int bytes_sent = 0;
  int reg_writes = 0;
  int idle_pct   = 6;
  int stall_pct  = 6;

  logic [7:0] tx_q[$];

  nmea_sentence_field_extractor_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  nmea_sentence_field_extractor_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .chars_o      (chars_seen),
    .ends_o       (ends_seen),
    .ends_ok_o    (ends_ok)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results still expected", CycleLimit, pending);
    $display("nmea_sentence_field_extractor_top regression: fail");
    $finish;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
  endfunction

  function automatic logic [7:0] body_char();
    logic [7:0] b;
    if ($urandom_range(9) < 8) begin
      b = 8'h2D + 8'($urandom_range(8'h2D));
    end else begin
      do b = 8'($urandom_range(255));
      while (b == ChDollar || b == ChStar || b == ChComma);
    end
    return b;
  endfunction

  function automatic logic [39:0] random_header();
    logic [39:0] h;
    int          k;
    case ($urandom_range(3))
      0:       h = "GPRMC";
      1:       h = "GNGGA";
      2:       h = "GPGSA";
      default: h = "GLGSV";
    endcase
    if ($urandom_range(9) == 0) begin
      for (k = 0; k < 5; k++)
        if ($urandom_range(2) == 0) begin
          do h[8*k +: 8] = 8'($urandom_range(255));
          while (h[8*k +: 8] == ChDollar);
        end
    end
    return h;
  endfunction

  function automatic ck_mode_e pick_ck();
    int r;
    r = $urandom_range(99);
    if (r < 80) return CK_GOOD;
    if (r < 90) return CK_BAD;
    if (r < 95) return CK_RAW;
    return CK_NONE;
  endfunction

  task automatic add_sentence(input logic [39:0] hdr, input int nfields, input int len_lo,
                              input int len_hi, input ck_mode_e mode);
    logic [7:0] ck;
    logic [7:0] b;
    int         f;
    int         k;
    int         len;
    tx_q.push_back(ChDollar);
    ck = 8'd0;
    for (k = 4; k >= 0; k--) begin
      b = hdr[8*k +: 8];
      tx_q.push_back(b);
      ck ^= b;
    end
    for (f = 0; f < nfields; f++) begin
      tx_q.push_back(ChComma);
      ck ^= ChComma;
      len = $urandom_range(len_hi, len_lo);
      for (k = 0; k < len; k++) begin
        b = body_char();
        tx_q.push_back(b);
        ck ^= b;
      end
    end
    if (mode == CK_BAD) ck ^= 8'($urandom_range(255, 1));
    case (mode)
      CK_GOOD, CK_BAD: begin
        tx_q.push_back(ChStar);
        tx_q.push_back(hex_char(ck[7:4]));
        tx_q.push_back(hex_char(ck[3:0]));
      end
      CK_RAW: begin
        tx_q.push_back(ChStar);
        tx_q.push_back(8'($urandom_range(255)));
        tx_q.push_back(8'($urandom_range(255)));
      end
      default: ;
    endcase
    if ($urandom_range(1) == 1) begin
      tx_q.push_back(8'h0D);
      tx_q.push_back(8'h0A);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i);
    while (!s_axis_tready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic flush_tx();
    while (tx_q.size() != 0) send_byte(tx_q.pop_front());
  endtask

  // only while the block is idle: every expected result out, then a further wait
  task automatic write_reg(input logic idx, input logic [5:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i);
    while (!cfg_ready);
    reg_writes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_random();
    int r;
    r = $urandom_range(99);
    if (r < 68) begin
      add_sentence(random_header(), $urandom_range(8, 1), 0, 8, pick_ck());
    end else if (r < 80) begin
      repeat ($urandom_range(8, 1)) tx_q.push_back(8'($urandom_range(255)));
    end else if (r < 86) begin
      add_sentence(random_header(), $urandom_range(40, 33), 0, 1, pick_ck());
    end else if (r < 91) begin
      add_sentence(random_header(), 1, 64, 75, pick_ck());
    end else if (r < 94) begin
      add_sentence(random_header(), 10, 12, 16, CK_GOOD);
    end else begin
      add_sentence(random_header(), $urandom_range(4, 1), 0, 6, CK_NONE);
    end
  endtask

  task automatic run_random(input int count);
    int start_count;
    start_count = bytes_sent;
    while (bytes_sent - start_count < count) begin
      add_random();
      flush_tx();
    end
  endtask

  task automatic run_directed();
    add_sentence("GPRMC", 2, 1, 2, CK_GOOD);
    add_sentence("GNGGA", 2, 0, 1, CK_GOOD);
    add_sentence("GPGSA", 1, 1, 1, CK_BAD);
    add_sentence("GPGSV", 1, 1, 1, CK_RAW);
    // separators inside the header still count as header bytes
    add_sentence("*,RMC", 1, 1, 1, CK_GOOD);
    add_sentence("GPVTG", 1, 1, 1, CK_GOOD);
    // new sentence while one is in its body; the last one is left inside its checksum digits
    add_sentence("GPGGA", 0, 0, 0, CK_NONE);
    tx_q.push_back(ChComma);
    tx_q.push_back(8'h00);
    tx_q.push_back(8'hFF);
    add_sentence("GPGSV", 1, 1, 1, CK_NONE);
    tx_q.push_back(ChStar);
    tx_q.push_back("4");
    flush_tx();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CfgFieldCharLimit;
    cfg_data      = 6'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();

    idle_pct  = 0;
    stall_pct = 0;
    run_random(140);
    idle_pct  = 6;
    stall_pct = 6;

    write_reg(CfgFieldCharLimit, 6'd63);
    run_random(140);

    write_reg(CfgFieldCharLimit, 6'd1);
    write_reg(CfgTypeEnableMask, 6'b000101);
    run_random(140);

    write_reg(CfgTypeEnableMask, 6'd0);
    run_random(40);

    write_reg(CfgFieldCharLimit, 6'($urandom_range(63, 1)));
    write_reg(CfgTypeEnableMask, 6'($urandom_range(15, 1)));
    run_random(140);

    write_reg(CfgFieldCharLimit, 6'd16);
    write_reg(CfgTypeEnableMask, 6'd15);
    run_random(140);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("covered %0d bytes across %0d register writes (limits 1 to 63, masks 0 to 15)",
             bytes_sent, reg_writes);
    $display("seen %0d field characters and %0d sentence ends, %0d with a matching checksum",
             chars_seen, ends_seen, ends_ok);
    if (fail_count == 0 && pending == 0) begin
      $display("nmea_sentence_field_extractor_top regression: pass");
    end else begin
      $display("nmea_sentence_field_extractor_top regression: fail");
    end
    $finish;
  end

endmodule
